FILE: sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants of the wheel speed PI controller
// Widths of the encoder count and of the speed divider, register indexes,
// queue entry and result layouts, and the drive direction codes.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Encoder counter width (range 16..64)
  localparam int unsigned COUNT_WIDTH = 32;

  // Count magnitude is clamped to 2^40, so it needs at most 41 bits
  localparam int unsigned MAG_W       = (COUNT_WIDTH > 41) ? 41 : COUNT_WIDTH;
  localparam logic [63:0] MAG_CLAMP   = 64'h0000_0100_0000_0000;

  // Speed scale 960000 = 3750 * 2^8
  localparam int unsigned SCALE_W     = 12;
  localparam logic [SCALE_W-1:0] SCALE_ODD = 12'd3750;
  localparam int unsigned SCALE_SHIFT = 8;

  // Divider sizing
  localparam int unsigned DIVIDEND_W  = MAG_W + SCALE_W + SCALE_SHIFT;
  localparam int unsigned DIVISOR_W   = 32;
  localparam int unsigned QUOT_W      = 24;
  localparam int unsigned REM_W       = (DIVIDEND_W > DIVISOR_W + QUOT_W) ?
                                        DIVIDEND_W : DIVISOR_W + QUOT_W;
  localparam int unsigned STEP_W      = $clog2(QUOT_W);
  localparam logic [QUOT_W-1:0] MEAS_MAX = 24'd8388607;

  // Configuration registers
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 39;
  localparam logic [15:0] PROP_GAIN_RST      = 16'd128;
  localparam logic [15:0] INTEG_GAIN_RST     = 16'd13;
  localparam logic [15:0] COUNTS_PER_REV_RST = 16'd210;
  localparam logic [38:0] INTEGRAL_LIMIT_RST = 39'd268435456;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_COUNTS_PER_REV,
    REG_INTEGRAL_LIMIT
  } wsp_reg_e;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_COUNT_UP,
    OP_COUNT_DOWN,
    OP_CONTROL,
    OP_HOLD
  } wsp_op_e;

  typedef struct packed {
    wsp_op_e            op;
    logic signed [15:0] setpoint;
    logic [15:0]        elapsed;
  } wsp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wsp_fifo_status_t;

  // Drive direction
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } wsp_dir_e;

  typedef struct packed {
    logic [31:0]        position;
    logic signed [23:0] measured_rpm;
    wsp_dir_e           direction;
    logic [7:0]         pwm_duty;
    logic               interval_invalid;
  } wsp_result_t;

endpackage

FILE: sv/wsp_front.sv
// ----------------------------------------------------------------------------
// wsp_front: input beat decoder
// Accepts input beats, sorts them into count steps and control updates, and
// pushes them into the work queue. Encoder events with phase B high drop.
// ----------------------------------------------------------------------------
module wsp_front (
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [39:0]               s_axis_tdata,
  input  logic                      s_axis_tuser,
  input  wsp_pkg::wsp_fifo_status_t fifo_status_i,
  output logic                      push_o,
  output wsp_pkg::wsp_entry_t       entry_o
);

  logic        phase_a;
  logic        phase_b;
  logic [15:0] elapsed;
  logic        keep;

  assign phase_a = s_axis_tdata[0];
  assign phase_b = s_axis_tdata[1];
  assign elapsed = s_axis_tdata[33:18];

  // Take a beat whenever the queue has room
  assign s_axis_tready = !fifo_status_i.full;

  // Classify the beat
  always_comb begin
    entry_o.setpoint = s_axis_tdata[17:2];
    entry_o.elapsed  = elapsed;
    if (s_axis_tuser) begin
      keep       = 1'b1;
      entry_o.op = (elapsed == 16'd0) ? wsp_pkg::OP_HOLD : wsp_pkg::OP_CONTROL;
    end else begin
      keep       = !phase_b;
      entry_o.op = phase_a ? wsp_pkg::OP_COUNT_DOWN : wsp_pkg::OP_COUNT_UP;
    end
  end

  assign push_o = s_axis_tvalid && s_axis_tready && keep;

endmodule

FILE: sv/wsp_fifo.sv
// ----------------------------------------------------------------------------
// wsp_fifo: work queue
// Small register queue that decouples the decoder from the control engine.
// ----------------------------------------------------------------------------
module wsp_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  wsp_pkg::wsp_entry_t       wdata_i,
  input  logic                      pop_i,
  output wsp_pkg::wsp_entry_t       rdata_o,
  output wsp_pkg::wsp_fifo_status_t status_o
);

  wsp_pkg::wsp_entry_t             entries_q [wsp_pkg::FIFO_DEPTH];
  logic [wsp_pkg::FIFO_AW-1:0]     wr_ptr_q;
  logic [wsp_pkg::FIFO_AW-1:0]     rd_ptr_q;
  logic [wsp_pkg::FIFO_AW:0]       count_q;
  logic                            do_push;
  logic                            do_pop;

  assign status_o.full  = (count_q == (wsp_pkg::FIFO_AW + 1)'(wsp_pkg::FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rdata_o        = entries_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= wdata_i;
  end

endmodule

FILE: sv/wsp_back.sv
// ----------------------------------------------------------------------------
// wsp_back: control engine
// Applies count steps, and for each control update measures speed with a
// restoring divider, runs the PI law and loads the result register.
// ----------------------------------------------------------------------------
module wsp_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wsp_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wsp_pkg::wsp_entry_t                 entry_i,
  input  wsp_pkg::wsp_fifo_status_t           fifo_status_i,
  output logic                                pop_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output wsp_pkg::wsp_result_t                res_o
);

  localparam int unsigned CW = wsp_pkg::COUNT_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_MEAS,
    ST_ERR,
    ST_PROD,
    ST_INT,
    ST_ITM,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration
  logic [15:0] prop_gain_q;
  logic [15:0] integ_gain_q;
  logic [15:0] cpr_q;
  logic [38:0] int_limit_q;

  // Channel state
  logic [CW-1:0]       enc_q;
  logic [CW-1:0]       prev_q;
  logic signed [39:0]  integ_q;
  logic [7:0]          last_pwm_q;
  wsp_pkg::wsp_dir_e   last_dir_q;
  logic                hold_q;
  logic [wsp_pkg::STEP_W-1:0] step_q;
  logic                res_valid_q;
  wsp_pkg::wsp_result_t res_q;

  // Datapath
  logic signed [15:0]             sp_q;
  logic [15:0]                    el_q;
  logic                           neg_q;
  logic [wsp_pkg::MAG_W-1:0]      mag_q;
  logic [wsp_pkg::DIVIDEND_W-1:0] dividend_q;
  logic [wsp_pkg::DIVISOR_W-1:0]  divisor_q;
  logic [wsp_pkg::REM_W-1:0]      rem_q;
  logic [wsp_pkg::REM_W-1:0]      dsh_q;
  logic [wsp_pkg::QUOT_W-1:0]     quot_q;
  logic signed [23:0]             meas_q;
  logic signed [24:0]             err_q;
  logic signed [40:0]             prod_q;
  logic signed [40:0]             pterm_q;
  logic signed [55:0]             iterm_q;

  // Combinational helpers
  logic [CW-1:0]                  delta;
  logic [CW-1:0]                  mag_full;
  logic [63:0]                    mag64;
  logic [63:0]                    mag_sat;
  logic [15:0]                    cpr_eff;
  logic [wsp_pkg::MAG_W+wsp_pkg::SCALE_W-1:0] scaled;
  logic [wsp_pkg::REM_W-1:0]      sat_bound;
  logic [wsp_pkg::QUOT_W-1:0]     quot_sat;
  logic signed [24:0]             sp_x;
  logic signed [24:0]             meas_x;
  logic signed [41:0]             err_x;
  logic signed [41:0]             el_x;
  logic signed [41:0]             pg_x;
  logic signed [41:0]             prod_full;
  logic signed [41:0]             pterm_full;
  logic signed [41:0]             isum;
  logic signed [41:0]             lim_p;
  logic signed [41:0]             lim_n;
  logic signed [41:0]             iclamp;
  logic signed [56:0]             iterm_full;
  logic signed [56:0]             sum;
  logic [7:0]                     duty;
  logic signed [63:0]             pos_ext;
  logic                           can_load;
  logic                           load_res;

  // Count magnitude since the previous update, clamped
  always_comb begin
    delta    = enc_q - prev_q;
    mag_full = delta[CW-1] ? (~delta + 1'b1) : delta;
    mag64    = 64'(mag_full);
    mag_sat  = (mag64 > wsp_pkg::MAG_CLAMP) ? wsp_pkg::MAG_CLAMP : mag64;
  end

  assign cpr_eff   = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
  assign scaled    = (wsp_pkg::MAG_W + wsp_pkg::SCALE_W)'(mag_q) *
                     (wsp_pkg::MAG_W + wsp_pkg::SCALE_W)'(wsp_pkg::SCALE_ODD);
  assign sat_bound = wsp_pkg::REM_W'(divisor_q) << wsp_pkg::QUOT_W;
  assign quot_sat  = (quot_q > wsp_pkg::MEAS_MAX) ? wsp_pkg::MEAS_MAX : quot_q;

  // PI arithmetic
  always_comb begin
    sp_x       = 25'(sp_q);
    meas_x     = 25'(meas_q);
    err_x      = 42'(err_q);
    el_x       = 42'({1'b0, el_q});
    pg_x       = 42'({1'b0, prop_gain_q});
    prod_full  = err_x * el_x;
    pterm_full = err_x * pg_x;
    isum       = 42'(integ_q) + 42'(prod_q);
    lim_p      = 42'({1'b0, int_limit_q});
    lim_n      = -lim_p;
    if (isum > lim_p) begin
      iclamp = lim_p;
    end else if (isum < lim_n) begin
      iclamp = lim_n;
    end else begin
      iclamp = isum;
    end
    iterm_full = 57'(integ_q) * 57'({1'b0, integ_gain_q});
    sum        = 57'(pterm_q) + 57'(iterm_q);
    if (sum[56]) begin
      duty = 8'd0;
    end else if (|sum[56:16]) begin
      duty = 8'hFF;
    end else begin
      duty = sum[15:8];
    end
  end

  assign pos_ext     = 64'(signed'(enc_q));
  assign can_load    = !res_valid_q || res_ready_i;
  assign load_res    = (state_q == ST_OUT) && can_load;
  assign pop_o       = (state_q == ST_IDLE) && !fifo_status_i.empty;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Sequence control, channel state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prop_gain_q  <= wsp_pkg::PROP_GAIN_RST;
      integ_gain_q <= wsp_pkg::INTEG_GAIN_RST;
      cpr_q        <= wsp_pkg::COUNTS_PER_REV_RST;
      int_limit_q  <= wsp_pkg::INTEGRAL_LIMIT_RST;
      enc_q        <= '0;
      prev_q       <= '0;
      integ_q      <= '0;
      last_pwm_q   <= '0;
      last_dir_q   <= wsp_pkg::DIR_STOP;
      hold_q       <= 1'b0;
      step_q       <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      // Write configuration
      if (cfg_we_i) begin
        case (cfg_addr_i)
          wsp_pkg::REG_PROP_GAIN:      prop_gain_q  <= cfg_wdata_i[15:0];
          wsp_pkg::REG_INTEG_GAIN:     integ_gain_q <= cfg_wdata_i[15:0];
          wsp_pkg::REG_COUNTS_PER_REV: cpr_q        <= cfg_wdata_i[15:0];
          wsp_pkg::REG_INTEGRAL_LIMIT: int_limit_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      // Raise the result on load, drop it once taken
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (!fifo_status_i.empty) begin
            case (entry_i.op)
              wsp_pkg::OP_COUNT_UP:   enc_q <= enc_q + 1'b1;
              wsp_pkg::OP_COUNT_DOWN: enc_q <= enc_q - 1'b1;
              wsp_pkg::OP_CONTROL: begin
                hold_q  <= 1'b0;
                state_q <= ST_MUL;
              end
              wsp_pkg::OP_HOLD: begin
                hold_q  <= 1'b1;
                state_q <= ST_OUT;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: state_q <= ST_CHK;
        ST_CHK: begin
          step_q  <= wsp_pkg::STEP_W'(wsp_pkg::QUOT_W - 1);
          state_q <= (wsp_pkg::REM_W'(dividend_q) >= sat_bound) ? ST_MEAS : ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) state_q <= ST_MEAS;
        end
        ST_MEAS: state_q <= ST_ERR;
        ST_ERR:  state_q <= ST_PROD;
        ST_PROD: state_q <= ST_INT;
        ST_INT: begin
          integ_q <= iclamp[39:0];
          state_q <= ST_ITM;
        end
        ST_ITM: state_q <= ST_OUT;
        ST_OUT: begin
          if (can_load) begin
            res_q.position    <= pos_ext[31:0];
            res_q.interval_invalid <= hold_q;
            if (hold_q) begin
              res_q.pwm_duty     <= last_pwm_q;
              res_q.direction    <= last_dir_q;
              res_q.measured_rpm <= '0;
            end else begin
              res_q.measured_rpm <= meas_q;
              prev_q             <= enc_q;
              if (sp_q == 16'sd0) begin
                res_q.pwm_duty  <= 8'd0;
                res_q.direction <= wsp_pkg::DIR_STOP;
                last_pwm_q      <= 8'd0;
                last_dir_q      <= wsp_pkg::DIR_STOP;
              end else if (sp_q[15]) begin
                res_q.pwm_duty  <= duty;
                res_q.direction <= wsp_pkg::DIR_BACK;
                last_pwm_q      <= duty;
                last_dir_q      <= wsp_pkg::DIR_BACK;
              end else begin
                res_q.pwm_duty  <= duty;
                res_q.direction <= wsp_pkg::DIR_FWD;
                last_pwm_q      <= duty;
                last_dir_q      <= wsp_pkg::DIR_FWD;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sp_q  <= entry_i.setpoint;
        el_q  <= entry_i.elapsed;
        neg_q <= delta[CW-1];
        mag_q <= mag_sat[wsp_pkg::MAG_W-1:0];
      end
      ST_MUL: begin
        dividend_q <= {scaled, {wsp_pkg::SCALE_SHIFT{1'b0}}};
        divisor_q  <= wsp_pkg::DIVISOR_W'(cpr_eff) * wsp_pkg::DIVISOR_W'(el_q);
      end
      ST_CHK: begin
        rem_q  <= wsp_pkg::REM_W'(dividend_q);
        dsh_q  <= wsp_pkg::REM_W'(divisor_q) << (wsp_pkg::QUOT_W - 1);
        quot_q <= (wsp_pkg::REM_W'(dividend_q) >= sat_bound) ? wsp_pkg::MEAS_MAX : '0;
      end
      ST_DIV: begin
        // One quotient bit per cycle
        if (rem_q >= dsh_q) begin
          rem_q  <= rem_q - dsh_q;
          quot_q <= {quot_q[wsp_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          quot_q <= {quot_q[wsp_pkg::QUOT_W-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      ST_MEAS: meas_q <= neg_q ? -signed'(quot_sat) : signed'(quot_sat);
      ST_ERR:  err_q  <= sp_q[15] ? (meas_x - sp_x) : (sp_x - meas_x);
      ST_PROD: begin
        prod_q  <= prod_full[40:0];
        pterm_q <= pterm_full[40:0];
      end
      ST_ITM:  iterm_q <= iterm_full[55:0];
      default: ;
    endcase
  end

endmodule

FILE: sv/wheel_speed_pi_controller.sv
// ----------------------------------------------------------------------------
// wheel_speed_pi_controller: one wheel channel of a PI speed controller
// Encoder beats (tuser 0) step the position count by one in the control
// engine and give no result. A control beat (tuser 1) goes from leaving the
// queue to its result through the scale multiply, the saturation check, the
// 24-step restoring divider that turns the count delta into 1/16 rpm, then
// quotient sign, error, products, integrator clamp, integral term and output.
// When the speed saturates the divider is skipped. A control beat with zero
// elapsed time goes straight to output and repeats the last drive with
// interval_invalid set. A four-entry queue lets beats arrive while an update
// is in work; tready falls only when it is full. The result stays in an
// output register until taken, and the engine waits there if needed. Gains
// are unsigned Q8.8; write configuration only when the block is idle.
// ----------------------------------------------------------------------------
module wheel_speed_pi_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [wsp_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [wsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // phase_a, phase_b, setpoint_rpm[15:0],
                                                        // elapsed_ms[15:0], zero pad
  input  logic                           s_axis_tuser,  // cmd
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [71:0]                    m_axis_tdata,  // pwm_duty[7:0], direction[1:0],
                                                        // measured_rpm[23:0], position[31:0],
                                                        // zero pad
  output logic                           m_axis_tuser   // interval_invalid
);

  wsp_pkg::wsp_fifo_status_t fifo_status;
  wsp_pkg::wsp_entry_t       push_entry;
  wsp_pkg::wsp_entry_t       pop_entry;
  wsp_pkg::wsp_result_t      result;
  logic                      push;
  logic                      pop;

  // Decode input beats
  wsp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  // Queue work between decoder and engine
  wsp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_entry),
    .pop_i    (pop),
    .rdata_o  (pop_entry),
    .status_o (fifo_status)
  );

  // Run the control law
  wsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_i       (pop_entry),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_o         (result)
  );

  // Pack the result beat
  assign m_axis_tdata = {6'b0, result.position, result.measured_rpm,
                         result.direction, result.pwm_duty};
  assign m_axis_tuser = result.interval_invalid;

endmodule

FILE: sv/wsp_checker.sv
// ----------------------------------------------------------------------------
// wsp_checker: port-level checks of the wheel speed PI controller
// Watches the result stream for drive codes and flag consistency.
// ----------------------------------------------------------------------------
module wsp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tuser
);

  logic [1:0] dir;
  assign dir = m_axis_tdata[9:8];

  // Hold a stalled result beat
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // Direction is stop, forward or backward
  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (dir == wsp_pkg::DIR_STOP || dir == wsp_pkg::DIR_FWD ||
                       dir == wsp_pkg::DIR_BACK))
    else $error("bad direction code");

  // Stopped motor has zero duty
  a_stop_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (dir == wsp_pkg::DIR_STOP) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("duty nonzero while stopped");

  // Repeated drive reports zero speed
  a_hold_meas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[33:10] == 24'd0))
    else $error("speed nonzero on invalid interval");

endmodule

bind wheel_speed_pi_controller wsp_checker u_wsp_checker (.*);
